FILE: design/sis_pkg.sv
`default_nettype none

package sis_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_GET    = 3'd3;
    localparam logic [OP_W-1:0] OP_POP    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [ST_W-1:0] ST_RANGE     = 3'd5;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_INS,
        SH_REM
    } shift_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EVAL,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic                     cmp;
        shift_t                   shift;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         count;
        logic [IDX_W-1:0]         sel;
    } bcast_t;

    typedef struct packed {
        logic [IDX_W-1:0]  pos;
        logic              hit;
        logic [DATA_W-1:0] rd;
    } probe_t;

endpackage

`default_nettype wire

FILE: design/sis_cell.sv
`default_nettype none

module sis_cell
    import sis_pkg::*;
(
    input  wire logic                     aclk,
    input  wire bcast_t                   bcast,
    input  wire logic [IDX_W-1:0]         cell_idx,
    input  wire logic signed [DATA_W-1:0] left_entry,
    input  wire logic signed [DATA_W-1:0] right_entry,
    input  wire logic                     left_lt,
    output logic signed [DATA_W-1:0]      entry,
    output logic                          lt,
    output logic                          eq,
    output logic                          first,
    output logic [DATA_W-1:0]             rd
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     lt_reg;
    logic                     eq_reg;
    logic [DATA_W-1:0]        rd_reg;
    logic                     valid;

    assign valid = {1'b0, cell_idx} < bcast.count;
    assign first = left_lt & ~lt_reg;

    always_comb begin
        entry_next = entry_reg;
        unique case (bcast.shift)
            SH_INS: begin
                if (!lt_reg) begin
                    entry_next = first ? bcast.value : left_entry;
                end
            end
            SH_REM: begin
                if (!lt_reg) begin
                    entry_next = right_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (bcast.cmp) begin
            lt_reg <= valid && (entry_reg < bcast.value);
            eq_reg <= valid && (entry_reg == bcast.value);
            rd_reg <= (cell_idx == bcast.sel) ? entry_reg : '0;
        end
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;
    assign rd    = rd_reg;

endmodule

`default_nettype wire

FILE: design/sis_array.sv
`default_nettype none

module sis_array
    import sis_pkg::*;
(
    input  wire logic   aclk,
    input  wire bcast_t bcast,
    output probe_t      probe
);

    logic signed [DATA_W-1:0] entry_w [CAPACITY];
    logic [DATA_W-1:0]        rd_w    [CAPACITY];
    logic [CAPACITY-1:0]      lt_w;
    logic [CAPACITY-1:0]      eq_w;
    logic [CAPACITY-1:0]      first_w;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] left_e;
        logic signed [DATA_W-1:0] right_e;
        logic                     left_l;

        if (g == 0) begin : g_head
            assign left_e = entry_w[g];
            assign left_l = 1'b1;
        end else begin : g_mid
            assign left_e = entry_w[g-1];
            assign left_l = lt_w[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_e = entry_w[g];
        end else begin : g_body
            assign right_e = entry_w[g+1];
        end

        sis_cell u_cell (
            .aclk        (aclk),
            .bcast       (bcast),
            .cell_idx    (IDX_W'(g)),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_lt     (left_l),
            .entry       (entry_w[g]),
            .lt          (lt_w[g]),
            .eq          (eq_w[g]),
            .first       (first_w[g]),
            .rd          (rd_w[g])
        );
    end

    always_comb begin
        probe = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_w[i]) begin
                probe.pos = probe.pos | IDX_W'(i);
            end
            probe.hit = probe.hit | eq_w[i];
            probe.rd  = probe.rd | rd_w[i];
        end
    end

endmodule

`default_nettype wire

FILE: design/sorted_int_set_table.sv
// Sorted set of signed 32-bit integers held in a row of compare-and-shift cells.
// Requests arrive as beats on the s_ channel: operation, value and index.
// Each request gives exactly one result beat on the m_ channel: status,
// found index, value read and the entry count after the request.
// The block takes one request at a time. A request accepted at one edge is
// broadcast to all cells in the next cycle, whose compare flags are reduced
// to a position, a hit and a read word in the cycle after, and the shift and
// count update happen in the apply step, when the result is loaded into the
// output register. The result beat is valid once that register is loaded,
// and the next request is taken only after the accept, broadcast, reduction
// and shift steps of the last one are through.
// A new request is accepted while the previous result still waits in the
// output register. If the receiver stalls, the block holds in its last step
// until the output register frees, and then completes the waiting request.
// Reset clears the entry count and the handshake state; the cell contents
// are left as they are and never read before being written.
`default_nettype none

module sorted_int_set_table
    import sis_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // operation[2:0], value[34:3], index[44:35], zero[47:45]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata   // status[2:0], found_index[12:3], value_out[44:13],
                                       // entry_count[55:45]
);

    state_t                   state_reg;
    state_t                   state_next;
    logic [OP_W-1:0]          op_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]         index_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [IDX_W-1:0]         pos_reg;
    logic                     hit_reg;
    logic [DATA_W-1:0]        rd_reg;
    logic [ST_W-1:0]          status_reg;
    logic [ST_W-1:0]          status_next;
    logic [IDX_W-1:0]         found_reg;
    logic [IDX_W-1:0]         found_next;
    logic [DATA_W-1:0]        vout_reg;
    logic [DATA_W-1:0]        vout_next;
    logic [CNT_W-1:0]         cnt_out_reg;
    logic                     m_valid_reg;
    shift_t                   dec_shift;
    logic                     out_free;
    logic                     s_accept;
    logic                     apply_go;
    bcast_t                   bcast;
    probe_t                   probe;

    sis_array u_array (
        .aclk  (aclk),
        .bcast (bcast),
        .probe (probe)
    );

    assign out_free = ~m_valid_reg | m_tready;
    assign s_accept = s_tvalid & s_tready;
    assign apply_go = (state_reg == S_APPLY) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_CMP;
            S_CMP:   state_next = S_EVAL;
            S_EVAL:  state_next = S_APPLY;
            S_APPLY: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == S_IDLE);
        bcast.cmp   = (state_reg == S_CMP);
        bcast.shift = apply_go ? dec_shift : SH_NONE;
        bcast.value = value_reg;
        bcast.count = count_reg;
        bcast.sel   = (op_reg == OP_GET) ? index_reg : (count_reg[IDX_W-1:0] - 1'b1);
    end

    always_comb begin
        status_next = ST_OK;
        found_next  = '0;
        vout_next   = '0;
        count_next  = count_reg;
        dec_shift   = SH_NONE;
        unique case (op_reg)
            OP_INSERT: begin
                if (hit_reg) begin
                    status_next = ST_DUPLICATE;
                    found_next  = pos_reg;
                end else if (count_reg >= CNT_W'(CAPACITY)) begin
                    status_next = ST_FULL;
                end else begin
                    found_next = pos_reg;
                    count_next = count_reg + 1'b1;
                    dec_shift  = SH_INS;
                end
            end
            OP_FIND: begin
                if (hit_reg) begin
                    found_next = pos_reg;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_REMOVE: begin
                if (hit_reg) begin
                    found_next = pos_reg;
                    count_next = count_reg - 1'b1;
                    dec_shift  = SH_REM;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_GET: begin
                if (CNT_W'(index_reg) < count_reg) begin
                    vout_next = rd_reg;
                end else begin
                    status_next = ST_RANGE;
                end
            end
            OP_POP: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    vout_next  = rd_reg;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (apply_go) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg    <= s_tdata[2:0];
            value_reg <= s_tdata[34:3];
            index_reg <= s_tdata[44:35];
        end
        if (state_reg == S_EVAL) begin
            pos_reg <= probe.pos;
            hit_reg <= probe.hit;
            rd_reg  <= probe.rd;
        end
        if (apply_go) begin
            status_reg  <= status_next;
            found_reg   <= found_next;
            vout_reg    <= vout_next;
            cnt_out_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {cnt_out_reg, vout_reg, found_reg, status_reg};

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

import sis_pkg::*;

localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
} request_t;

typedef struct packed {
    logic [ST_W-1:0]          status;
    logic [IDX_W-1:0]         found_index;
    logic signed [DATA_W-1:0] value_out;
    logic [CNT_W-1:0]         entry_count;
} result_t;

class set_scoreboard;
    logic signed [DATA_W-1:0] members[$];
    result_t                  pending_results[$];
    int                       pending_tags[$];
    string                    issues[$];
    int                       requests_seen;
    int                       results_checked;
    int                       peak_size;
    int                       op_seen[8];
    int                       status_seen[8];

    function int lower_pos(logic signed [DATA_W-1:0] v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = members.size();
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (members[mid] < v) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function bit holds(logic signed [DATA_W-1:0] v);
        int pos;
        pos = lower_pos(v);
        return (pos < members.size()) && (members[pos] == v);
    endfunction

    function void note_request(request_t r);
        result_t res;
        int      pos;
        bit      hit;
        res = '0;
        pos = lower_pos(r.value);
        hit = (pos < members.size()) && (members[pos] == r.value);
        case (r.op)
            OP_INSERT: begin
                if (hit) begin
                    res.status      = ST_DUPLICATE;
                    res.found_index = pos[IDX_W-1:0];
                end else if (members.size() >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    members.insert(pos, r.value);
                    res.found_index = pos[IDX_W-1:0];
                end
            end
            OP_FIND: begin
                if (hit) begin
                    res.found_index = pos[IDX_W-1:0];
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    members.delete(pos);
                    res.found_index = pos[IDX_W-1:0];
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            OP_GET: begin
                if (int'(r.index) < members.size()) begin
                    res.value_out = members[r.index];
                end else begin
                    res.status = ST_RANGE;
                end
            end
            OP_POP: begin
                if (members.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value_out = members.pop_back();
                end
            end
            OP_CLEAR: begin
                members.delete();
            end
            default: begin
            end
        endcase
        res.entry_count = CNT_W'(members.size());
        if (members.size() > peak_size) begin
            peak_size = members.size();
        end
        pending_results.push_back(res);
        pending_tags.push_back(requests_seen);
        op_seen[r.op]++;
        requests_seen++;
    endfunction

    function void check_beat(logic [55:0] beat);
        result_t got;
        result_t want;
        int      tag;
        got.status      = beat[2:0];
        got.found_index = beat[12:3];
        got.value_out   = beat[44:13];
        got.entry_count = beat[55:45];
        if (pending_results.size() == 0) begin
            issues.push_back("Result beat arrived with no request outstanding.");
            return;
        end
        want = pending_results.pop_front();
        tag  = pending_tags.pop_front();
        if (got.status != want.status) begin
            issues.push_back($sformatf("Request %0d: status %0d, expected %0d.",
                                       tag, got.status, want.status));
        end
        if (got.found_index != want.found_index) begin
            issues.push_back($sformatf("Request %0d: found_index %0d, expected %0d.",
                                       tag, got.found_index, want.found_index));
        end
        if (got.value_out != want.value_out) begin
            issues.push_back($sformatf("Request %0d: value_out %0d, expected %0d.",
                                       tag, got.value_out, want.value_out));
        end
        if (got.entry_count != want.entry_count) begin
            issues.push_back($sformatf("Request %0d: entry_count %0d, expected %0d.",
                                       tag, got.entry_count, want.entry_count));
        end
        status_seen[want.status]++;
        results_checked++;
    endfunction
endclass

module tb;

    localparam int LIMIT = 1000000;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    set_scoreboard sb;
    int  errors      = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  calm        = 1'b0;

    sorted_int_set_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < LIMIT) @(posedge aclk);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report(string what);
        errors++;
        if (errors <= 40) begin
            $display("Mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(negedge aclk) begin
        if (stall_left == 0 && !calm && $urandom_range(0, 99) < 25) begin
            stall_left = gap_length();
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_beat(m_tdata);
            while (sb.issues.size() != 0) begin
                report(sb.issues.pop_front());
            end
        end
    end

    task automatic issue(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v,
                         logic [IDX_W-1:0] idx);
        request_t r;
        int       gap;
        r.op    = op;
        r.value = v;
        r.index = idx;
        gap = (!calm && $urandom_range(0, 99) < 35) ? gap_length() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, r.index, r.value, r.op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(r);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return $signed($urandom_range(0, 40)) - 20;
        end else if (r < 70 && sb.members.size() != 0) begin
            return sb.members[$urandom_range(0, sb.members.size() - 1)];
        end else if (r < 88) begin
            return $urandom;
        end
        case ($urandom_range(0, 5))
            0: return VAL_MIN;
            1: return VAL_MIN + 1;
            2: return VAL_MAX;
            3: return VAL_MAX - 1;
            4: return -1;
            default: return 0;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = sb.members.size();
        if (r < 75 && n > 0) begin
            return IDX_W'($urandom_range(0, n - 1));
        end else if (r < 85) begin
            return IDX_W'(n);
        end
        return IDX_W'($urandom_range(0, 1023));
    endfunction

    task automatic run_directed();
        calm = 1'b0;
        issue(OP_POP, 0, 0);
        issue(OP_GET, 0, 0);
        issue(OP_FIND, 7, 0);
        issue(OP_REMOVE, 7, 0);
        issue(OP_INSERT, VAL_MAX, 0);
        issue(OP_INSERT, VAL_MIN, 0);
        issue(OP_INSERT, 0, 0);
        issue(OP_INSERT, -1, 0);
        issue(OP_INSERT, 1, 0);
        issue(OP_INSERT, VAL_MAX, 0);
        issue(OP_FIND, VAL_MIN, 0);
        issue(OP_FIND, VAL_MAX, 0);
        issue(OP_FIND, 5, 0);
        issue(OP_REMOVE, 0, 0);
        issue(OP_REMOVE, 2, 0);
        issue(OP_GET, 0, 0);
        issue(OP_GET, 0, 3);
        issue(OP_GET, 0, 4);
        issue(OP_GET, VAL_MAX, 10'h3FF);
        issue(OP_SPARE_6, -1, 10'h3FF);
        issue(OP_SPARE_7, VAL_MIN, 10'h155);
        issue(OP_POP, 0, 0);
        issue(OP_CLEAR, 3, 2);
        issue(OP_POP, 0, 0);
        issue(OP_INSERT, 42, 0);
    endtask

    task automatic run_full_store();
        logic signed [DATA_W-1:0] v;
        issue(OP_CLEAR, 0, 0);
        while (sb.members.size() < CAPACITY) begin
            issue(OP_INSERT, $urandom, IDX_W'($urandom));
        end
        do begin
            v = $urandom;
        end while (sb.holds(v));
        issue(OP_INSERT, v, 0);
        issue(OP_INSERT, sb.members[$urandom_range(0, CAPACITY - 1)], 0);
        issue(OP_INSERT, sb.members[0], 0);
        issue(OP_INSERT, sb.members[CAPACITY - 1], 0);
        issue(OP_GET, 0, 10'h3FF);
        issue(OP_GET, 0, 0);
        issue(OP_FIND, sb.members[512], 0);
        issue(OP_FIND, v, 0);
        issue(OP_REMOVE, sb.members[700], 0);
        issue(OP_INSERT, v, 0);
        issue(OP_INSERT, ~v, 0);
        issue(OP_POP, 0, 0);
        issue(OP_CLEAR, 0, 0);
        issue(OP_POP, 0, 0);
    endtask

    task automatic run_random();
        int n;
        int r;
        logic [OP_W-1:0] op;
        for (n = 0; n < 650; n++) begin
            calm = (n % 160) < 30;
            r = $urandom_range(0, 99);
            if (r < 40) begin
                op = OP_INSERT;
            end else if (r < 54) begin
                op = OP_FIND;
            end else if (r < 67) begin
                op = OP_REMOVE;
            end else if (r < 83) begin
                op = OP_GET;
            end else if (r < 96) begin
                op = OP_POP;
            end else if (r < 97) begin
                op = OP_CLEAR;
            end else if (r < 98) begin
                op = OP_SPARE_6;
            end else begin
                op = OP_SPARE_7;
            end
            issue(op, pick_value(), pick_index());
        end
        calm = 1'b0;
    endtask

    initial begin
        sb = new;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_full_store();
        run_random();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        $display(
            "Requests %0d: insert %0d, find %0d, remove %0d, get %0d, pop %0d, clear %0d, other %0d.",
            sb.requests_seen, sb.op_seen[OP_INSERT], sb.op_seen[OP_FIND],
            sb.op_seen[OP_REMOVE], sb.op_seen[OP_GET], sb.op_seen[OP_POP],
            sb.op_seen[OP_CLEAR], sb.op_seen[OP_SPARE_6] + sb.op_seen[OP_SPARE_7]);
        $display(
            "Results %0d: duplicate %0d, full %0d, absent %0d, empty %0d, range %0d; peak %0d.",
            sb.results_checked, sb.status_seen[ST_DUPLICATE], sb.status_seen[ST_FULL],
            sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_EMPTY],
            sb.status_seen[ST_RANGE], sb.peak_size);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
design/sis_pkg.sv
design/sis_cell.sv
design/sis_array.sv
design/sorted_int_set_table.sv
test/tb.sv
